// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Every form is clocked on clk and
// disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge.
`define TVCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The antecedent this cycle implies the consequent in the next cycle.
`define TVCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tvca_pkg.sv =====
// ---------------------------------------------------------------------------
// tvca_pkg
// Types and constants for the timed voice channel allocator.
// ---------------------------------------------------------------------------
package tvca_pkg;

  localparam int TIME_W     = 64;
  localparam int COUNT_W    = 32;
  localparam int RATE_W     = 20;
  localparam int VOICE_W    = 3;
  localparam int HW_W       = 4;
  localparam int MASK_W     = 8;
  localparam int VOL_W      = 8;
  localparam int NUM_VOICES = 8;

  // Timing and voice split
  localparam int TICKS_PER_MS  = 268112;
  localparam int EFFECT_VOICES = 7;
  localparam int MS_PER_S      = 1000;
  localparam int LEN_SCALE     = MS_PER_S * TICKS_PER_MS;
  localparam int SCALE_W       = $clog2(LEN_SCALE + 1);
  localparam int PROD_W        = COUNT_W + SCALE_W;

  // Candidate counter holds values up to the effect voice count and start+1
  localparam int CAND_W    = 4;
  localparam int DIV_CNT_W = $clog2(TIME_W + 1);

  localparam logic [VOICE_W-1:0] MUSIC_VOICE   = 3'd7;
  localparam logic [HW_W-1:0]    HW_VOICE_BASE = 4'd8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_VOLUME  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_PLAY_FX    = 2'd0,
    FUNC_PLAY_MUSIC = 2'd1,
    FUNC_HALT_ONE   = 2'd2,
    FUNC_HALT_ALL   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_NO_VOICE = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [TIME_W-1:0]  now_tick;
    logic               sample_ok;
    logic [COUNT_W-1:0] sample_count;
    logic [RATE_W-1:0]  sample_rate;
    logic               repeat_req;
    logic [VOICE_W-1:0] voice_sel;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [VOICE_W-1:0] granted_voice;
    logic [HW_W-1:0]    hw_voice;
    logic               repeat_out;
    logic [MASK_W-1:0]  stop_mask;
    logic               music_playing;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/timed_voice_channel_allocator.sv =====
// ---------------------------------------------------------------------------
// timed_voice_channel_allocator
// Eight-voice allocator with play end times, round-robin effect search,
// fixed music voice and halt requests.
// ---------------------------------------------------------------------------
// One request is in work at a time; the next is accepted in the cycle after
// the previous result has been placed in the output register, even if that
// result has not yet been taken downstream. Halt requests and gated play
// requests go from decode straight to the done state, which loads the output
// register once it is free. A play that starts a voice goes through decode,
// for an effect a search over up to EFFECT_VOICES voices (one voice end time
// compared per cycle), the bit-serial divider, a commit of the end time and
// the load of the output register. The divider dominates; it works out
// sample_count*1000*TICKS_PER_MS/sample_rate one quotient bit per cycle.
// An effect search that finds no free voice ends after its last compare.
// The end-time store is eight flip-flop words cleared directly by reset, so
// there is no clearing pass after reset. Configuration writes take effect at
// once and are expected only while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_voice_channel_allocator (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tvca_pkg::req_t                   in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output tvca_pkg::rsp_t                   out_data,
  // configuration writes
  input  logic                             cfg_wen,
  input  logic [tvca_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tvca_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tvca_pkg::*;

  localparam logic [SCALE_W-1:0] ScaleK = SCALE_W'(LEN_SCALE);

  // Reduce a small value modulo the effect voice count; input is at most 8,
  // so four conditional subtracts always suffice.
  function automatic logic [CAND_W-1:0] wrap_ev(input logic [CAND_W-1:0] x);
    logic [CAND_W-1:0] v;
    v = x;
    for (int k = 0; k < 4; k++) begin
      if (v >= CAND_W'(EFFECT_VOICES)) begin
        v = v - CAND_W'(EFFECT_VOICES);
      end
    end
    return v;
  endfunction

  // Configuration registers
  logic             sound_enabled;
  logic [VOL_W-1:0] effect_volume;
  logic [VOL_W-1:0] music_volume;

  // Allocator state
  logic [TIME_W-1:0]  voice_end_time [NUM_VOICES];
  logic [VOICE_W-1:0] search_pointer;
  logic [VOICE_W-1:0] search_pointer_next;

  // Request in work and its pending result
  state_t             state;
  state_t             state_next;
  req_t               req;
  rsp_t               res;
  rsp_t               res_next;
  rsp_t               res_out;
  logic [CAND_W-1:0]  cnt;
  logic [CAND_W-1:0]  cnt_next;
  logic [CAND_W-1:0]  steps;
  logic [CAND_W-1:0]  steps_next;
  logic [VOICE_W-1:0] voice;
  logic [VOICE_W-1:0] voice_next;

  // End-time write controls
  logic               end_we;
  logic               end_clr_all;
  logic [VOICE_W-1:0] end_idx;
  logic [TIME_W-1:0]  end_val;

  // Divider
  logic               div_start;
  logic [PROD_W-1:0]  len_prod;
  logic [TIME_W-1:0]  div_dividend;
  logic [RATE_W-1:0]  div_divisor;
  logic [TIME_W-1:0]  div_quot;
  div_stat_t          div_stat;

  logic               load_out;
  logic [VOICE_W-1:0] cand;
  logic               play_ok;

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enabled <= 1'b0;
      effect_volume <= VOL_W'(64);
      music_volume  <= VOL_W'(64);
    end else if (cfg_wen) begin
      priority case (cfg_idx)
        CFG_SOUND_ENABLED: sound_enabled <= cfg_wdata[0];
        CFG_EFFECT_VOLUME: effect_volume <= cfg_wdata[VOL_W-1:0];
        CFG_MUSIC_VOLUME:  music_volume  <= cfg_wdata[VOL_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---- length numerator and divider ---------------------------------------
  // sample_count * 1000 * TICKS_PER_MS is one constant multiply straight into
  // the divider's shift register; a zero rate divides as a rate of one.
  assign len_prod     = req.sample_count * ScaleK;
  assign div_dividend = TIME_W'(len_prod);
  assign div_divisor  = (req.sample_rate == '0) ? RATE_W'(1) : req.sample_rate;

  tvca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // ---- control ------------------------------------------------------------
  assign in_ready = (state == S_IDLE);
  assign cand     = cnt[VOICE_W-1:0];
  assign play_ok  = sound_enabled && req.sample_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    res_next            = res;
    cnt_next            = cnt;
    steps_next          = steps;
    voice_next          = voice;
    search_pointer_next = search_pointer;
    div_start           = 1'b0;
    end_we              = 1'b0;
    end_clr_all         = 1'b0;
    end_idx             = voice;
    end_val             = '0;
    load_out            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_next        = '0;
        res_next.status = STATUS_OK;
        unique case (req.func)
          FUNC_PLAY_FX: begin
            if (!play_ok || effect_volume == '0) begin
              res_next.status = STATUS_REJECTED;
              state_next      = S_DONE;
            end else begin
              // round-robin starts one past the last voice examined
              cnt_next   = wrap_ev(CAND_W'(search_pointer) + CAND_W'(1));
              steps_next = CAND_W'(1);
              state_next = S_SEARCH;
            end
          end
          FUNC_PLAY_MUSIC: begin
            if (!play_ok || music_volume == '0) begin
              res_next.status = STATUS_REJECTED;
              state_next      = S_DONE;
            end else begin
              voice_next = MUSIC_VOICE;
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
          FUNC_HALT_ONE: begin
            end_we             = 1'b1;
            end_idx            = req.voice_sel;
            res_next.stop_mask = MASK_W'(1) << req.voice_sel;
            state_next         = S_DONE;
          end
          FUNC_HALT_ALL: begin
            end_clr_all        = 1'b1;
            res_next.stop_mask = '1;
            state_next         = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end

      S_SEARCH: begin
        // free when the current tick is strictly past the voice's end time
        if (req.now_tick > voice_end_time[cand]) begin
          search_pointer_next = cand;
          voice_next          = cand;
          div_start           = 1'b1;
          state_next          = S_DIV;
        end else if (steps == CAND_W'(EFFECT_VOICES)) begin
          search_pointer_next = cand;
          res_next.status     = STATUS_NO_VOICE;
          state_next          = S_DONE;
        end else begin
          cnt_next   = (cnt == CAND_W'(EFFECT_VOICES - 1)) ? '0 : cnt + CAND_W'(1);
          steps_next = steps + CAND_W'(1);
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          end_we                 = 1'b1;
          end_idx                = voice;
          end_val                = req.now_tick + div_quot;  // wraps mod 2^64
          res_next.granted_voice = voice;
          res_next.hw_voice      = HW_VOICE_BASE + HW_W'(voice);
          res_next.repeat_out    = req.repeat_req;
          state_next             = S_DONE;
        end
      end

      S_DONE: begin
        // end times are already updated, so music status sees this request
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // ---- datapath registers -------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    res   <= res_next;
    cnt   <= cnt_next;
    steps <= steps_next;
    voice <= voice_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pointer <= '0;
    end else begin
      search_pointer <= search_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || end_clr_all) begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        voice_end_time[k] <= '0;
      end
    end else if (end_we) begin
      voice_end_time[end_idx] <= end_val;
    end
  end

  // ---- output register ----------------------------------------------------
  always_comb begin
    res_out               = res;
    res_out.music_playing = req.now_tick < voice_end_time[MUSIC_VOICE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res_out;
    end
  end

  // ---- assertions ---------------------------------------------------------
  `TVCA_ASSERT(a_idle_div_quiet, in_ready |-> !div_stat.busy, "divider busy while idle")
  `TVCA_ASSERT_NXT(a_div_done_commit, div_stat.done, state == S_DONE, "quotient not committed")
  `TVCA_ASSERT_NXT(a_halt_all_clears, state == S_DECODE && req.func == FUNC_HALT_ALL, voice_end_time[0] == '0 && voice_end_time[MUSIC_VOICE] == '0, "halt all left an end time")
  `TVCA_ASSERT(a_ptr_range, int'(search_pointer) < EFFECT_VOICES || EFFECT_VOICES > NUM_VOICES, "search pointer outside effect voices")

endmodule

// ===== rtl/tvca_div.sv =====
// ---------------------------------------------------------------------------
// tvca_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module tvca_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tvca_pkg::TIME_W-1:0]    dividend,
  input  logic [tvca_pkg::RATE_W-1:0]    divisor,
  output logic [tvca_pkg::TIME_W-1:0]    quotient,
  output tvca_pkg::div_stat_t            stat
);
  import tvca_pkg::*;

  // Dividend bits leave at the top, quotient bits enter at the bottom
  logic [TIME_W-1:0]    shreg;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [RATE_W:0]      rem_sh;
  logic [RATE_W:0]      diff;
  logic                 take;

  always_comb begin
    rem_sh = {rem, shreg[TIME_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    take   = !diff[RATE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(TIME_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[TIME_W-2:0], take};
      rem   <= take ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    end
  end

  assign quotient  = shreg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
